// File: sv/le_advertising_report_parser_defines.svh
// Assertion macros for the advertising report parser.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef LE_ADVERTISING_REPORT_PARSER_DEFINES_SVH
`define LE_ADVERTISING_REPORT_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define LARP_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LARP_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LARP_ASSERT_IMPL(label, clk, rst, prop, msg)
`define LARP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: sv/larp_pkg.sv
// Shared types and constants for the advertising report parser.
// No dependencies.
`default_nettype none
package larp_pkg;
   localparam logic [7:0] IND_EVENT  = 8'h04;
   localparam logic [7:0] EVT_LE     = 8'h3E;
   localparam logic [7:0] SUB_ADV    = 8'h02;

   typedef enum logic [3:0] {
      K_NONE = 4'd0, K_EVTYPE = 4'd1, K_ADDRTYPE = 4'd2, K_ADDR = 4'd3,
      K_FLAGS = 4'd4, K_UUID16 = 4'd5, K_UUID128 = 4'd6, K_NAME = 4'd7,
      K_MFR = 4'd8, K_OTHER = 4'd9, K_DONE = 4'd10, K_DROPPED = 4'd11,
      K_OK = 4'd12, K_ERROR = 4'd13, K_IGNORED = 4'd14
   } kind_type;

   localparam logic [2:0] E_NONE = 3'd0;
   localparam logic [2:0] E_IND  = 3'd1;
   localparam logic [2:0] E_SHORT = 3'd2;
   localparam logic [2:0] E_LEN  = 3'd3;
   localparam logic [2:0] E_EVT  = 3'd4;
   localparam logic [2:0] E_TRUNC = 3'd5;

   typedef struct packed {
      logic [3:0]  kind;
      logic [15:0] value;
      logic [7:0]  position;
      logic [7:0]  report_number;
      logic [7:0]  structure_type;
      logic [2:0]  error_code;
      logic        last;
   } result_type;

   // one queue entry: up to two results caused by one byte
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   function automatic logic [3:0] ad_kind(input logic [7:0] t);
      logic [3:0] k;
      case (t)
         8'h01: k = K_FLAGS;
         8'h02, 8'h03: k = K_UUID16;
         8'h06, 8'h07: k = K_UUID128;
         8'h08, 8'h09: k = K_NAME;
         8'hFF: k = K_MFR;
         default: k = K_OTHER;
      endcase
      return k;
   endfunction
endpackage
`default_nettype wire

// File: sv/larp_front.sv
// Front end: consumes packet bytes and produces a queue entry for each byte that yields a result or ends the packet.
// Depends on larp_pkg.
`default_nettype none
module larp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           data_byte,
   input  wire logic                 end_of_packet,
   output larp_pkg::entry_type       entry,
   output logic                      entry_valid
);
   typedef enum logic [3:0] {
      PH_IND, PH_EVT, PH_LEN, PH_SUB, PH_NREP, PH_EVTYPE, PH_ADDRTYPE, PH_ADDR,
      PH_ADLEN, PH_CHLEN, PH_CHTYPE, PH_CHDATA, PH_RSSI, PH_DRAIN, PH_IGNORE, PH_TAIL
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [8:0] evl_ff, evl_in;
   logic [7:0] rl_ff, rl_in, rc_ff, rc_in;
   logic [2:0] ac_ff, ac_in;
   logic [7:0] adl_ff, adl_in, cbl_ff, cbl_in, ct_ff, ct_in, pc_ff, pc_in, ulb_ff, ulb_in;
   logic       cor_ff, cor_in;
   logic [2:0] perr_ff, perr_in;

   logic       d_v;
   logic [3:0] d_k;
   logic [15:0] d_val;
   logic [7:0] d_pos, d_st;
   logic [7:0] adm, cbm;
   logic [2:0] err;
   logic [3:0] vk;
   logic       corr;

   always_comb begin
      phase_in = phase_ff; evl_in = evl_ff; rl_in = rl_ff; rc_in = rc_ff;
      ac_in = ac_ff; adl_in = adl_ff; cbl_in = cbl_ff; ct_in = ct_ff;
      pc_in = pc_ff; ulb_in = ulb_ff; cor_in = cor_ff; perr_in = perr_ff;
      d_v = 1'b0; d_k = larp_pkg::K_NONE; d_val = '0; d_pos = '0; d_st = '0;
      adm = adl_ff - 8'd1;
      cbm = cbl_ff - 8'd1;
      corr = cor_ff;
      err = larp_pkg::E_NONE; vk = larp_pkg::K_OK;
      entry = '0;
      if (phase_ff == PH_IND) begin
         if (data_byte == larp_pkg::IND_EVENT) phase_in = PH_EVT;
         else begin
            if (perr_ff == 3'd0 || perr_ff > larp_pkg::E_IND) perr_in = larp_pkg::E_IND;
            phase_in = PH_DRAIN;
         end
      end else if (phase_ff == PH_EVT) begin
         if (data_byte != larp_pkg::EVT_LE &&
             (perr_ff == 3'd0 || perr_ff > larp_pkg::E_EVT)) perr_in = larp_pkg::E_EVT;
         phase_in = PH_LEN;
      end else if (phase_ff == PH_LEN) begin
         evl_in = {1'b0, data_byte};
         phase_in = (perr_ff != 3'd0) ? PH_DRAIN : PH_SUB;
      end else if (evl_ff == 9'd0) begin
         if (perr_ff == 3'd0 || perr_ff > larp_pkg::E_LEN) perr_in = larp_pkg::E_LEN;
         phase_in = PH_DRAIN;
      end else begin
         evl_in = evl_ff - 9'd1;
         unique case (phase_ff)
            PH_SUB: phase_in = (data_byte == larp_pkg::SUB_ADV) ? PH_NREP : PH_IGNORE;
            PH_NREP: begin
               rl_in = data_byte; rc_in = '0;
               phase_in = (data_byte == 8'd0) ? PH_TAIL : PH_EVTYPE;
            end
            PH_EVTYPE: begin
               cor_in = 1'b0;
               d_v = 1'b1; d_k = larp_pkg::K_EVTYPE; d_val = {8'd0, data_byte};
               phase_in = PH_ADDRTYPE;
            end
            PH_ADDRTYPE: begin
               d_v = 1'b1; d_k = larp_pkg::K_ADDRTYPE; d_val = {8'd0, data_byte};
               ac_in = '0; phase_in = PH_ADDR;
            end
            PH_ADDR: begin
               d_v = 1'b1; d_k = larp_pkg::K_ADDR; d_val = {8'd0, data_byte};
               d_pos = {5'd0, ac_ff};
               ac_in = ac_ff + 3'd1;
               if (ac_ff == 3'd5 || ac_ff == 3'd6 || ac_ff == 3'd7) phase_in = PH_ADLEN;
            end
            PH_ADLEN: begin
               adl_in = data_byte;
               phase_in = (data_byte == 8'd0) ? PH_RSSI : PH_CHLEN;
            end
            PH_CHLEN: begin
               adl_in = adm;
               if (data_byte == 8'd0 || data_byte > adm) begin
                  cor_in = 1'b1;
                  phase_in = (adm == 8'd0) ? PH_RSSI : PH_CHDATA;
               end else begin
                  cbl_in = data_byte; phase_in = PH_CHTYPE;
               end
            end
            PH_CHTYPE: begin
               adl_in = adm; cbl_in = cbm; ct_in = data_byte;
               pc_in = '0; ulb_in = '0;
               if ((data_byte == 8'h02 || data_byte == 8'h03) && cbm[0]) corr = 1'b1;
               if ((data_byte == 8'h06 || data_byte == 8'h07) && cbm[3:0] != 4'd0)
                  corr = 1'b1;
               cor_in = corr;
               if (corr) phase_in = (adm == 8'd0) ? PH_RSSI : PH_CHDATA;
               else if (cbm == 8'd0) phase_in = (adm == 8'd0) ? PH_RSSI : PH_CHLEN;
               else phase_in = PH_CHDATA;
            end
            PH_CHDATA: begin
               adl_in = adm;
               if (cor_ff) begin
                  if (adm == 8'd0) phase_in = PH_RSSI;
               end else begin
                  cbl_in = cbm;
                  if (larp_pkg::ad_kind(ct_ff) == larp_pkg::K_UUID16) begin
                     if (!pc_ff[0]) ulb_in = data_byte;
                     else begin
                        d_v = 1'b1; d_k = larp_pkg::K_UUID16;
                        d_val = {data_byte, ulb_ff}; d_pos = pc_ff - 8'd1; d_st = ct_ff;
                     end
                  end else begin
                     d_v = 1'b1; d_k = larp_pkg::ad_kind(ct_ff);
                     d_val = {8'd0, data_byte}; d_pos = pc_ff; d_st = ct_ff;
                  end
                  pc_in = pc_ff + 8'd1;
                  if (cbm == 8'd0) phase_in = (adm == 8'd0) ? PH_RSSI : PH_CHLEN;
               end
            end
            PH_RSSI: begin
               d_v = 1'b1; d_k = cor_ff ? larp_pkg::K_DROPPED : larp_pkg::K_DONE;
               d_val = {8'd0, data_byte};
               rc_in = rc_ff + 8'd1; rl_in = rl_ff - 8'd1; cor_in = 1'b0;
               phase_in = (rl_ff == 8'd1) ? PH_TAIL : PH_EVTYPE;
            end
            default: ;
         endcase
      end

      if (perr_in == larp_pkg::E_IND || perr_in == larp_pkg::E_LEN) err = perr_in;
      else if (phase_in == PH_EVT || phase_in == PH_LEN) err = larp_pkg::E_SHORT;
      else if (evl_in != 9'd0) err = larp_pkg::E_LEN;
      else if (perr_in != 3'd0) err = perr_in;
      else if (phase_in == PH_IGNORE) vk = larp_pkg::K_IGNORED;
      else if (phase_in != PH_TAIL) err = larp_pkg::E_TRUNC;
      if (err != 3'd0) vk = larp_pkg::K_ERROR;

      // data result uses the report count before this byte
      if (d_v) begin
         entry.r0 = '{kind: d_k, value: d_val, position: d_pos, report_number: rc_ff,
                      structure_type: d_st, error_code: 3'd0, last: !end_of_packet};
         if (end_of_packet) begin
            entry.two = 1'b1;
            entry.r1 = '{kind: vk, value: 16'd0, position: 8'd0, report_number: rc_in,
                         structure_type: 8'd0, error_code: err, last: 1'b1};
         end
      end else if (end_of_packet) begin
         entry.r0 = '{kind: vk, value: 16'd0, position: 8'd0, report_number: rc_in,
                      structure_type: 8'd0, error_code: err, last: 1'b1};
      end
      entry_valid = d_v | end_of_packet;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_packet)) begin
         phase_ff <= PH_IND; evl_ff <= '0; rl_ff <= '0; rc_ff <= '0; ac_ff <= '0;
         adl_ff <= '0; cbl_ff <= '0; ct_ff <= '0; pc_ff <= '0; ulb_ff <= '0;
         cor_ff <= 1'b0; perr_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in; evl_ff <= evl_in; rl_ff <= rl_in; rc_ff <= rc_in;
         ac_ff <= ac_in; adl_ff <= adl_in; cbl_ff <= cbl_in; ct_ff <= ct_in;
         pc_ff <= pc_in; ulb_ff <= ulb_in; cor_ff <= cor_in; perr_ff <= perr_in;
      end
   end
endmodule
`default_nettype wire

// File: sv/larp_queue.sv
// Short FIFO of result entries between front and back.
// Depends on larp_pkg.
`default_nettype none
module larp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire larp_pkg::entry_type  push_data,
   input  wire logic                 pop,
   output larp_pkg::entry_type       head,
   output logic                      not_empty,
   output logic                      not_full
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   larp_pkg::entry_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;

   assign not_empty = cnt_ff != '0;
   assign not_full  = cnt_ff != (AW+1)'(DEPTH);
   assign head = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         if (pop)  rp_ff <= (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule
`default_nettype wire

// File: sv/larp_back.sv
// Back end: unpacks queue entries into one result transaction per cycle while rsp_stall is low.
// Depends on larp_pkg.
`default_nettype none
module larp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire larp_pkg::entry_type  head,
   input  wire logic                 head_valid,
   output logic                      pop,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output larp_pkg::result_type      rsp
);
   logic sel_ff;
   logic rsp_valid_ff;
   larp_pkg::result_type rsp_ff;
   logic load;
   logic take_second;

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign take_second = sel_ff && head.two;
   assign pop = load && (!head.two || sel_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0; sel_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= head_valid;
         if (head_valid) sel_ff <= head.two && !sel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= take_second ? head.r1 : head.r0;
   end
endmodule
`default_nettype wire

// File: sv/le_advertising_report_parser.sv
// HCI LE advertising report parser: one packet byte per cycle in while req_stall is low.
// A byte's first result passes through the queue and then the output register.
// A byte with a data result and a verdict yields two output transactions.
// A 4-entry queue decouples parsing from the output; req_stall rises only when it is full.
// Reset: synchronous, active high; parser returns to expecting the indicator, queue empties.
`default_nettype none
`include "le_advertising_report_parser_defines.svh"
module le_advertising_report_parser #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_packet,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_kind,
   output logic [15:0]      rsp_value,
   output logic [7:0]       rsp_position,
   output logic [7:0]       rsp_report_number,
   output logic [7:0]       rsp_structure_type,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_last
);
   larp_pkg::entry_type  entry, head;
   larp_pkg::result_type rsp;
   logic entry_valid, not_empty, not_full, pop, step;

   assign req_stall = !not_full;
   assign step = req_valid && not_full;

   larp_front u_front (
      .clock(clock), .reset(reset), .step(step), .data_byte(req_data_byte),
      .end_of_packet(req_end_of_packet), .entry(entry), .entry_valid(entry_valid)
   );

   larp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(step && entry_valid), .push_data(entry),
      .pop(pop), .head(head), .not_empty(not_empty), .not_full(not_full)
   );

   larp_back u_back (
      .clock(clock), .reset(reset), .head(head), .head_valid(not_empty), .pop(pop),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   assign rsp_kind = rsp.kind;
   assign rsp_value = rsp.value;
   assign rsp_position = rsp.position;
   assign rsp_report_number = rsp.report_number;
   assign rsp_structure_type = rsp.structure_type;
   assign rsp_error_code = rsp.error_code;
   assign rsp_last = rsp.last;

   `LARP_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop |-> not_empty, "pop from empty queue")
   `LARP_ASSERT_IMPL(a_err_only_verdict, clock, reset,
      (rsp_valid && rsp_error_code != 3'd0) |-> (rsp_kind == larp_pkg::K_ERROR),
      "error code outside error verdict")
   `LARP_ASSERT_IMPL(a_verdict_last, clock, reset,
      (rsp_valid && (rsp_kind == larp_pkg::K_OK || rsp_kind == larp_pkg::K_ERROR ||
       rsp_kind == larp_pkg::K_IGNORED)) |-> rsp_last, "verdict not last")
endmodule
`default_nettype wire
